// ===== hw/rtl/bgnc_pkg.sv =====
// ============================================================================
// bgnc_pkg
// Shared types and constants for the binary grid neighbor count block.
// ============================================================================
`default_nettype none

package bgnc_pkg;

    localparam int CFG_W        = 9;
    localparam int MAX_SIZE_DEF = 256;
    localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(256);

    localparam int COUNT_W = 4;
    localparam int POS_W   = 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic mark_bit;
        logic pad_item;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] neighbor_count;
        logic [POS_W-1:0]   cell_row;
        logic [POS_W-1:0]   cell_column;
        logic               frame_end;
    } t_out_item;

    typedef struct packed {
        logic mid;
        logic up;
    } t_line_bits;

    typedef struct packed {
        logic      valid0;
        t_out_item data0;
        logic      valid1;
        t_out_item data1;
    } t_result_pair;

endpackage

`default_nettype wire

// ===== hw/rtl/bgnc_stream_if.sv =====
// ============================================================================
// bgnc_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ============================================================================
`default_nettype none

interface bgnc_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/binary_grid_neighbor_count.sv =====
// The count of cell (r,c) is pushed into the output queue when the input of cell
// (r+1,c+1) is accepted; the last column comes with the input of cell (r+1,n-1).
// Throughput: one input transaction per cycle, set by the chain of line cells that
// shifts once per input; ready falls only while the output queue holds over two.
// Reset clears positions, the window and the queue and sets the grid size to 256;
// the line cells are not cleared, as rows before their first write are gated off.
// ============================================================================
// binary_grid_neighbor_count
// Streaming 3x3 box sum over a square binary grid using a chain of line cells.
// ============================================================================
`default_nettype none

module binary_grid_neighbor_count
    import bgnc_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    bgnc_stream_if.sink           i_in_stream,
    bgnc_stream_if.source         o_out_stream
);

    localparam int CLAMP_INT = (MAX_SIZE > (1 << CFG_W) - 1) ? (1 << CFG_W) - 1 : MAX_SIZE;
    localparam logic [CFG_W-1:0] SIZE_CLAMP = CFG_W'(CLAMP_INT);

    function automatic logic [COUNT_W-1:0] count_ones(input logic [8:0] v);
        logic [COUNT_W-1:0] s;
        s = '0;
        for (int k = 0; k < 9; k++) begin
            s = s + COUNT_W'(v[k]);
        end
        return s;
    endfunction

    logic [CFG_W-1:0] r_grid;
    logic [CFG_W-1:0] r_row;
    logic [CFG_W-1:0] r_col;
    logic [8:0]       r_win;
    logic [CFG_W-1:0] n_row;
    logic [CFG_W-1:0] n_col;
    logic [8:0]       n_win;

    logic [CFG_W-1:0] w_size;
    logic             w_fire;
    logic             w_space;
    logic             w_bit;
    logic             w_top;
    logic             w_mid;
    logic [2:0]       w_newcol;
    logic [CFG_W-1:0] w_row_m1;
    logic [CFG_W-1:0] w_col_m1;
    t_result_pair     w_push;
    t_line_bits       w_entry;
    t_line_bits       w_cell [MAX_SIZE];
    t_line_bits       w_tail;

    assign w_size = (r_grid == '0) ? CFG_W'(1) :
                    (int'(r_grid) > MAX_SIZE) ? SIZE_CLAMP : r_grid;

    assign i_in_stream.ready = w_space;
    assign w_fire = i_in_stream.valid && w_space;

    assign w_tail      = w_cell[MAX_SIZE-1];
    assign w_entry.mid = w_bit;
    assign w_entry.up  = w_tail.mid;

    for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
        t_line_bits w_prev;
        if (i == 0) begin : g_head
            assign w_prev = w_entry;
        end else begin : g_link
            assign w_prev = w_cell[i-1];
        end
        bgnc_line_cell #(
            .MAX_SIZE (MAX_SIZE),
            .IDX      (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_fire),
            .i_size  (w_size),
            .i_prev  (w_prev),
            .i_entry (w_entry),
            .o_bits  (w_cell[i])
        );
    end

    always_comb begin
        w_bit = i_in_stream.payload.mark_bit && !i_in_stream.payload.pad_item &&
                (r_row != w_size);
        w_top = (r_row >= CFG_W'(2)) ? w_tail.up : 1'b0;
        w_mid = (r_row >= CFG_W'(1)) ? w_tail.mid : 1'b0;
        w_newcol = {w_bit, w_mid, w_top};
        n_win = (r_col == '0) ? {w_newcol, 6'b0} : {w_newcol, r_win[8:3]};
        w_row_m1 = r_row - CFG_W'(1);
        w_col_m1 = r_col - CFG_W'(1);

        w_push.valid0 = w_fire && (r_row != '0) && (r_col != '0);
        w_push.data0.neighbor_count = count_ones(n_win);
        w_push.data0.cell_row       = w_row_m1[POS_W-1:0];
        w_push.data0.cell_column    = w_col_m1[POS_W-1:0];
        w_push.data0.frame_end      = 1'b0;

        w_push.valid1 = w_fire && (r_row != '0) && (r_col == w_size - CFG_W'(1));
        w_push.data1.neighbor_count = count_ones({3'b0, n_win[8:3]});
        w_push.data1.cell_row       = w_row_m1[POS_W-1:0];
        w_push.data1.cell_column    = r_col[POS_W-1:0];
        w_push.data1.frame_end      = (r_row == w_size);

        n_row = r_row;
        n_col = r_col + CFG_W'(1);
        if (n_col >= w_size) begin
            n_col = '0;
            n_row = (r_row == w_size) ? '0 : r_row + CFG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= GRID_RESET;
            r_row  <= '0;
            r_col  <= '0;
            r_win  <= '0;
        end else if (i_cfg_we) begin
            r_grid <= i_cfg_wdata;
            r_row  <= '0;
            r_col  <= '0;
            r_win  <= '0;
        end else if (w_fire) begin
            r_row <= n_row;
            r_col <= n_col;
            r_win <= n_win;
        end
    end

    bgnc_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_space      (w_space),
        .o_out_stream (o_out_stream)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bgnc_line_cell.sv =====
// ============================================================================
// bgnc_line_cell
// One stage of the programmable line delay, holding a middle and upper bit.
// ============================================================================
`default_nettype none

module bgnc_line_cell
    import bgnc_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF,
    parameter int IDX      = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_shift,
    input  wire logic [CFG_W-1:0] i_size,
    input  wire t_line_bits       i_prev,
    input  wire t_line_bits       i_entry,
    output t_line_bits            o_bits
);

    localparam int ENTRY_SIZE = MAX_SIZE - IDX;

    t_line_bits r_bits;
    logic       w_is_entry;

    assign w_is_entry = (int'(i_size) == ENTRY_SIZE);
    assign o_bits     = r_bits;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_bits <= w_is_entry ? i_entry : i_prev;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bgnc_out_fifo.sv =====
// ============================================================================
// bgnc_out_fifo
// Small result queue that takes up to two results per cycle and sends one while ready is high.
// ============================================================================
`default_nettype none

module bgnc_out_fifo
    import bgnc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_result_pair i_push,
    output logic              o_space,
    bgnc_stream_if.source     o_out_stream
);

    t_out_item              r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_head;
    logic [FIFO_PTR_W-1:0]  r_tail;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic [FIFO_PTR_W-1:0]  n_head;
    logic [FIFO_PTR_W-1:0]  n_tail;
    logic [FIFO_CNT_W-1:0]  n_count;
    logic                   w_pop;
    logic [FIFO_CNT_W-1:0]  w_push_n;
    t_out_item              w_first;

    assign o_out_stream.valid   = (r_count != '0);
    assign o_out_stream.payload = r_mem[r_head];
    assign w_pop   = o_out_stream.valid && o_out_stream.ready;
    assign o_space = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    assign w_push_n = FIFO_CNT_W'(i_push.valid0) + FIFO_CNT_W'(i_push.valid1);
    assign w_first  = i_push.valid0 ? i_push.data0 : i_push.data1;

    always_comb begin
        n_head  = w_pop ? r_head + FIFO_PTR_W'(1) : r_head;
        n_tail  = r_tail + FIFO_PTR_W'(w_push_n);
        n_count = r_count + w_push_n - FIFO_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid0 || i_push.valid1) begin
            r_mem[r_tail] <= w_first;
        end
        if (i_push.valid0 && i_push.valid1) begin
            r_mem[r_tail + FIFO_PTR_W'(1)] <= i_push.data1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bgnc_checker.sv =====
// ============================================================================
// bgnc_checker
// Port-level checks on the result stream of the neighbor count block.
// ============================================================================
`default_nettype none

module bgnc_checker
    import bgnc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [COUNT_W-1:0] i_count,
    input wire logic [POS_W-1:0]   i_row,
    input wire logic [POS_W-1:0]   i_column,
    input wire logic               i_frame_end
);

    a_valid_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result valid dropped before its transaction.");

    a_payload_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_count) && $stable(i_row) && $stable(i_column) && $stable(i_frame_end))
        else $error("Stalled result payload changed.");

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_count <= COUNT_W'(9))
        else $error("Neighbor count above nine.");

    a_frame_end_corner : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_end |-> i_row == i_column)
        else $error("Frame end flagged off the last diagonal cell.");

    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result offered right after reset.");

endmodule

bind binary_grid_neighbor_count bgnc_checker u_bgnc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_stream.valid),
    .i_out_ready (o_out_stream.ready),
    .i_count     (o_out_stream.payload.neighbor_count),
    .i_row       (o_out_stream.payload.cell_row),
    .i_column    (o_out_stream.payload.cell_column),
    .i_frame_end (o_out_stream.payload.frame_end)
);

`default_nettype wire
